// ===== design/lwgs_pkg.sv =====
`default_nettype none

package lwgs_pkg;

    // Field widths fixed by the stream and register formats.
    localparam int RANGE_W    = 16;
    localparam int IDX_W      = 10;
    localparam int START_W    = 31;
    localparam int STEP_W     = 25;
    localparam int ANGLE_W    = 32;
    localparam int SPEED_W    = 16;
    localparam int BSUM_W     = 20;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;

    // Replacement for a sample outside the accepted range.
    localparam logic [RANGE_W-1:0] REPLACE_MM = 16'd5000;

    // Speed division: 0.5 in Q0.16 scaled by 2^28, over 2^28 + |angle|.
    localparam int                 DIV_STEPS    = 16;
    localparam int                 DIV_CNT_W    = 4;
    localparam logic [31:0]        ONE_Q28      = 32'h1000_0000;
    localparam logic [32:0]        DIV_REM_INIT = 33'h0_0800_0000;
    localparam logic [SPEED_W-1:0] SPEED_MAX    = 16'd32768;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RANGE_FLOOR   = 3'd0,
        CFG_RANGE_CEILING = 3'd1,
        CFG_FIRST_CENTER  = 3'd2,
        CFG_LAST_CENTER   = 3'd3,
        CFG_START_ANGLE   = 3'd4,
        CFG_ANGLE_STEP    = 3'd5
    } cfg_addr_t;

    typedef struct packed {
        logic [RANGE_W-1:0]        range_floor_mm;
        logic [RANGE_W-1:0]        range_ceiling_mm;
        logic [IDX_W-1:0]          first_center;
        logic [IDX_W-1:0]          last_center;
        logic signed [START_W-1:0] start_angle;
        logic [STEP_W-1:0]         angle_step;
    } cfg_t;

    // Outcome of one scan, handed from the window tracker to the steering unit.
    typedef struct packed {
        logic [IDX_W-1:0]  run_first;
        logic [IDX_W-1:0]  run_last;
        logic [BSUM_W-1:0] best_sum;
    } scan_rec_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ANG,
        ST_DIV,
        ST_DONE
    } back_state_t;

endpackage

`default_nettype wire

// ===== design/lidar_widest_gap_steering.sv =====
`default_nettype none

// Channel   Direction  Content
// s_axis    in         one range sample item; tlast marks the last sample of a scan
// m_axis    out        one steering item per scan
// cfg       in         register writes, no read-back
//
// The front end takes one sample item per cycle while its two-entry scan queue has room.
// Each scan's steering item is computed after its last sample by, in order,
// a 10 x 25 bit multiply, an add with clamp and a 16-step restoring divider.
// Reset is asynchronous and active low; it clears the scan state at once, with no sweep.
// A stalled output holds its item; the front end only stops when two scans are waiting.

module lidar_widest_gap_steering #(
    parameter int WINDOW_TAPS     = 9,
    parameter int MAX_SCAN_POINTS = 1024
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // Sample stream.
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [15:0]                         s_axis_tdata,  // [15:0] range_sample
    input  wire logic                                s_axis_tlast,  // end_of_scan
    // Steering stream.
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // [9:0] hole_index, [41:10] steer_angle, [57:42] forward_speed,
    // [77:58] best_window_sum, [79:78] zero
    output logic [79:0]                              m_axis_tdata,
    // Configuration writes.
    input  wire logic                                cfg_wr_en,
    input  wire logic [lwgs_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  wire logic [lwgs_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import lwgs_pkg::*;

    cfg_t      cfg_reg;
    logic      q_full;
    logic      q_empty;
    logic      q_push;
    logic      q_pop;
    scan_rec_t push_rec;
    scan_rec_t pop_rec;

    logic [IDX_W-1:0]          hole_index;
    logic signed [ANGLE_W-1:0] steer_angle;
    logic [SPEED_W-1:0]        forward_speed;
    logic [BSUM_W-1:0]         best_window_sum;

    // Configuration registers; a write to an unused index is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.range_floor_mm   <= 16'd100;
            cfg_reg.range_ceiling_mm <= 16'd30000;
            cfg_reg.first_center     <= 10'd222;
            cfg_reg.last_center      <= 10'd545;
            cfg_reg.start_angle      <= -31'sd843314857;
            cfg_reg.angle_step       <= 25'd2342691;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                CFG_RANGE_FLOOR:   cfg_reg.range_floor_mm   <= cfg_wdata[RANGE_W-1:0];
                CFG_RANGE_CEILING: cfg_reg.range_ceiling_mm <= cfg_wdata[RANGE_W-1:0];
                CFG_FIRST_CENTER:  cfg_reg.first_center     <= cfg_wdata[IDX_W-1:0];
                CFG_LAST_CENTER:   cfg_reg.last_center      <= cfg_wdata[IDX_W-1:0];
                CFG_START_ANGLE:   cfg_reg.start_angle      <= $signed(cfg_wdata[START_W-1:0]);
                CFG_ANGLE_STEP:    cfg_reg.angle_step       <= cfg_wdata[STEP_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Front end: cleans each sample, keeps the window sum and tracks the best run.
    lwgs_front #(
        .WINDOW_TAPS     (WINDOW_TAPS),
        .MAX_SCAN_POINTS (MAX_SCAN_POINTS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .range_sample (s_axis_tdata),
        .end_of_scan  (s_axis_tlast),
        .q_full       (q_full),
        .push         (q_push),
        .push_rec     (push_rec)
    );

    // Finished scans wait here so that the front end need not wait on the divider.
    lwgs_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_rec (push_rec),
        .full     (q_full),
        .pop      (q_pop),
        .pop_rec  (pop_rec),
        .empty    (q_empty)
    );

    // Back end: midpoint, steering angle and forward speed for each scan.
    lwgs_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .start_angle     (cfg_reg.start_angle),
        .angle_step      (cfg_reg.angle_step),
        .q_empty         (q_empty),
        .q_rec           (pop_rec),
        .q_pop           (q_pop),
        .out_valid       (m_axis_tvalid),
        .out_ready       (m_axis_tready),
        .hole_index      (hole_index),
        .steer_angle     (steer_angle),
        .forward_speed   (forward_speed),
        .best_window_sum (best_window_sum)
    );

    assign m_axis_tdata = {2'b00, best_window_sum, forward_speed, steer_angle, hole_index};

endmodule

`default_nettype wire

// ===== design/lwgs_front.sv =====
`default_nettype none

module lwgs_front #(
    parameter int WINDOW_TAPS     = 9,
    parameter int MAX_SCAN_POINTS = 1024
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire lwgs_pkg::cfg_t                cfg,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [lwgs_pkg::RANGE_W-1:0]  range_sample,
    input  wire logic                          end_of_scan,
    input  wire logic                          q_full,
    output logic                               push,
    output lwgs_pkg::scan_rec_t                push_rec
);
    import lwgs_pkg::*;

    localparam int HALF  = WINDOW_TAPS / 2;
    localparam int CNT_W = $clog2(MAX_SCAN_POINTS);
    localparam int SUM_W = RANGE_W + $clog2(WINDOW_TAPS);
    localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;

    logic [CNT_W-1:0]   cnt_reg;
    logic [RANGE_W-1:0] win_reg [WINDOW_TAPS];
    logic [SUM_W-1:0]   sum_reg;
    logic [SUM_W-1:0]   best_reg;
    logic [IDX_W-1:0]   first_reg;
    logic [IDX_W-1:0]   last_reg;

    logic [SUM_W-1:0]        sum_next;
    logic [SUM_W-1:0]        best_next;
    logic [IDX_W-1:0]        first_next;
    logic [IDX_W-1:0]        last_next;
    logic [CNT_W-1:0]        cnt_next;
    logic [RANGE_W-1:0]      clean;
    logic [CMP_W-1:0]        center;
    logic                    in_window;
    logic                    accept;
    logic [SUM_W+BSUM_W-1:0] best_wide;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign push     = accept && end_of_scan;

    always_comb
    begin
        if ((range_sample > cfg.range_floor_mm) && (range_sample < cfg.range_ceiling_mm))
        begin
            clean = range_sample;
        end
        else
        begin
            clean = REPLACE_MM;
        end

        // Running sum: the oldest sample leaves as the new one arrives.
        sum_next = sum_reg + SUM_W'(clean) - SUM_W'(win_reg[0]);

        center    = CMP_W'(cnt_reg) - CMP_W'(HALF);
        in_window = (cnt_reg >= CNT_W'(HALF))
                 && (center >= CMP_W'(cfg.first_center))
                 && (center <= CMP_W'(cfg.last_center));

        best_next  = best_reg;
        first_next = first_reg;
        last_next  = last_reg;
        if (in_window)
        begin
            if (sum_next > best_reg)
            begin
                best_next  = sum_next;
                first_next = center[IDX_W-1:0];
                last_next  = center[IDX_W-1:0];
            end
            else if (sum_next == best_reg)
            begin
                last_next = center[IDX_W-1:0];
            end
        end

        if (cnt_reg == CNT_W'(MAX_SCAN_POINTS - 1))
        begin
            cnt_next = '0;
        end
        else
        begin
            cnt_next = cnt_reg + 1'b1;
        end

        best_wide          = {{BSUM_W{1'b0}}, best_next};
        push_rec.run_first = first_next;
        push_rec.run_last  = last_next;
        push_rec.best_sum  = best_wide[BSUM_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            sum_reg   <= '0;
            best_reg  <= '0;
            first_reg <= '0;
            last_reg  <= '0;
            for (int i = 0; i < WINDOW_TAPS; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (accept)
        begin
            if (end_of_scan)
            begin
                cnt_reg   <= '0;
                sum_reg   <= '0;
                best_reg  <= '0;
                first_reg <= '0;
                last_reg  <= '0;
                for (int i = 0; i < WINDOW_TAPS; i++)
                begin
                    win_reg[i] <= '0;
                end
            end
            else
            begin
                cnt_reg   <= cnt_next;
                sum_reg   <= sum_next;
                best_reg  <= best_next;
                first_reg <= first_next;
                last_reg  <= last_next;
                for (int i = 0; i < WINDOW_TAPS - 1; i++)
                begin
                    win_reg[i] <= win_reg[i+1];
                end
                win_reg[WINDOW_TAPS-1] <= clean;
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/lwgs_queue.sv =====
`default_nettype none

module lwgs_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire lwgs_pkg::scan_rec_t push_rec,
    output logic                     full,
    input  wire logic                pop,
    output lwgs_pkg::scan_rec_t      pop_rec,
    output logic                     empty
);
    import lwgs_pkg::*;

    scan_rec_t   entry_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;

    logic do_push;
    logic do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_rec = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/lwgs_back.sv =====
`default_nettype none

module lwgs_back (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic signed [lwgs_pkg::START_W-1:0] start_angle,
    input  wire logic [lwgs_pkg::STEP_W-1:0]       angle_step,
    input  wire logic                              q_empty,
    input  wire lwgs_pkg::scan_rec_t               q_rec,
    output logic                                   q_pop,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [lwgs_pkg::IDX_W-1:0]             hole_index,
    output logic signed [lwgs_pkg::ANGLE_W-1:0]    steer_angle,
    output logic [lwgs_pkg::SPEED_W-1:0]           forward_speed,
    output logic [lwgs_pkg::BSUM_W-1:0]            best_window_sum
);
    import lwgs_pkg::*;

    localparam int PROD_W = IDX_W + STEP_W;
    localparam int FULL_W = PROD_W + 2;

    back_state_t          state_reg;
    back_state_t          state_next;
    logic [IDX_W-1:0]     hole_reg;
    logic [BSUM_W-1:0]    bsum_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [ANGLE_W-1:0]   angle_reg;
    logic [31:0]          divisor_reg;
    logic [32:0]          rem_reg;
    logic [SPEED_W-1:0]   quot_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 out_valid_reg;
    logic [IDX_W-1:0]     out_hole_reg;
    logic [ANGLE_W-1:0]   out_angle_reg;
    logic [SPEED_W-1:0]   out_speed_reg;
    logic [BSUM_W-1:0]    out_sum_reg;

    logic                     load_out;
    logic                     div_last;
    logic [IDX_W:0]           hole_sum;
    logic signed [FULL_W-1:0] ang_full;
    logic [ANGLE_W-1:0]       ang_sat;
    logic [ANGLE_W-1:0]       ang_mag;
    logic [32:0]              trial;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:  state_next = ST_ANG;
            ST_ANG:  state_next = ST_DIV;
            ST_DIV:
            begin
                if (div_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control outputs.
    always_comb
    begin
        q_pop    = (state_reg == ST_IDLE) && !q_empty;
        div_last = (state_reg == ST_DIV) && (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));
        load_out = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);
    end

    // Datapath helpers.
    always_comb
    begin
        hole_sum = {1'b0, q_rec.run_first} + {1'b0, q_rec.run_last};
        ang_full = FULL_W'(start_angle) + $signed({2'b00, prod_reg});

        // Clamp to the 32 bit signed range.
        if (!ang_full[FULL_W-1] && (|ang_full[FULL_W-2:ANGLE_W-1]))
        begin
            ang_sat = {1'b0, {(ANGLE_W-1){1'b1}}};
        end
        else if (ang_full[FULL_W-1] && !(&ang_full[FULL_W-2:ANGLE_W-1]))
        begin
            ang_sat = {1'b1, {(ANGLE_W-1){1'b0}}};
        end
        else
        begin
            ang_sat = ang_full[ANGLE_W-1:0];
        end

        if (ang_sat[ANGLE_W-1])
        begin
            ang_mag = ANGLE_W'(0) - ang_sat;
        end
        else
        begin
            ang_mag = ang_sat;
        end

        trial = {rem_reg[31:0], 1'b0};
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                hole_reg <= hole_sum[IDX_W:1];
                bsum_reg <= q_rec.best_sum;
            end
            ST_MUL:
            begin
                prod_reg <= hole_reg * angle_step;
            end
            ST_ANG:
            begin
                angle_reg   <= ang_sat;
                divisor_reg <= ONE_Q28 + ang_mag;
                rem_reg     <= DIV_REM_INIT;
                quot_reg    <= '0;
                cnt_reg     <= '0;
            end
            ST_DIV:
            begin
                // One restoring-division step per cycle; the dividend's low bits are zero.
                if (trial >= {1'b0, divisor_reg})
                begin
                    rem_reg  <= trial - {1'b0, divisor_reg};
                    quot_reg <= {quot_reg[SPEED_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= trial;
                    quot_reg <= {quot_reg[SPEED_W-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    out_hole_reg  <= hole_reg;
                    out_angle_reg <= angle_reg;
                    out_speed_reg <= quot_reg;
                    out_sum_reg   <= bsum_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign hole_index      = out_hole_reg;
    assign steer_angle     = out_angle_reg;
    assign forward_speed   = out_speed_reg;
    assign best_window_sum = out_sum_reg;

    a_div_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (rem_reg < {1'b0, divisor_reg}))
        else $error("division remainder not below divisor");

    a_div_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (divisor_reg >= ONE_Q28))
        else $error("speed divisor below one");

    a_speed_range: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> (quot_reg <= SPEED_MAX))
        else $error("forward speed above one half");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (state_reg == ST_MUL))
        else $error("record taken without starting the multiply");

endmodule

`default_nettype wire
